### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while aresetn is low
`define SFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SFS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// types, widths and helpers shared by the sprite frame sequencer
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int FRAME_BITS   = 10;
    localparam int LOOP_BITS    = FRAME_BITS + 1;
    localparam int TIME_BITS    = 32;
    localparam int STEP_BITS    = 16;
    localparam int ELAPSED_BITS = 16;
    localparam int COL_BITS     = 6;
    localparam int DIV_BITS     = COL_BITS + 1;
    localparam int SHEET_BITS   = 7;
    localparam int MAX_COLS     = 64;
    localparam int MIN_LOOP     = 2;
    localparam int CNT_BITS     = $clog2(FRAME_BITS + 1);

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 32;
    localparam int OUT_BITS     = FRAME_BITS + COL_BITS + FRAME_BITS + 2;
    localparam int OUT_PAD      = M_TDATA_BITS - OUT_BITS;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_FRAME   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_FRAME   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_ENABLE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHEET_COLUMNS = 3'd6;

    // input kinds
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic [FRAME_BITS-1:0] first_frame;
        logic [LOOP_BITS-1:0]  loop_length;
        logic [FRAME_BITS-1:0] start_frame;
        logic [TIME_BITS-1:0]  period;
        logic                  loop_enable;
        logic                  reverse;
        logic [SHEET_BITS-1:0] sheet_columns;
    } sfs_cfg_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  advanced;
        logic                  ended;
    } sfs_anim_t;

    typedef struct packed {
        logic                  done;
        logic [FRAME_BITS-1:0] quotient;
        logic [COL_BITS-1:0]   remainder;
    } sfs_div_t;

    // column count forced into 1..64
    function automatic logic [DIV_BITS-1:0] clamp_cols(input logic [SHEET_BITS-1:0] c);
        logic [DIV_BITS-1:0] r;
        if (c == '0) begin
            r = DIV_BITS'(1);
        end else if (c > SHEET_BITS'(MAX_COLS)) begin
            r = DIV_BITS'(MAX_COLS);
        end else begin
            r = DIV_BITS'(c);
        end
        return r;
    endfunction

endpackage

### rtl/sfs_anim.sv
// ----------------------------------------------------------------------------
// sfs_anim
// animation state: frame, time accumulator, step count and end flag
// ----------------------------------------------------------------------------
module sfs_anim (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              upd_en,
    input  logic                              cmd,
    input  logic [sfs_pkg::ELAPSED_BITS-1:0]  elapsed,
    input  sfs_pkg::sfs_cfg_t                 cfg,
    output sfs_pkg::sfs_anim_t                anim
);
    import sfs_pkg::*;

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [TIME_BITS-1:0]  acc_reg, acc_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  end_reg, end_next;
    logic                  adv_reg;

    logic [TIME_BITS:0]    acc_sum;
    logic [TIME_BITS-1:0]  acc_sat;
    logic [STEP_BITS:0]    step_inc;
    logic                  live, end_now, do_step;
    // range bounds need one bit above the loop length: first + length can reach 3070
    logic [LOOP_BITS:0]    lo, hi, fwd_n, prev_x, last_x;
    logic [FRAME_BITS-1:0] prev_f, fwd_f, rev_f, restart_f;
    logic                  fwd_in, rev_in;

    always_comb begin
        live     = (cfg.loop_length >= LOOP_BITS'(MIN_LOOP)) && (cfg.period != '0);
        acc_sum  = {1'b0, acc_reg} + (TIME_BITS + 1)'(elapsed);
        acc_sat  = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];
        step_inc = {1'b0, step_reg} + (STEP_BITS + 1)'(1);
        end_now  = end_reg ||
                   (!cfg.loop_enable && ((STEP_BITS + 1)'(cfg.loop_length) == step_inc));
        do_step  = (acc_sat > cfg.period) && !end_now;

        // loop range is [lo, hi)
        lo     = {2'b00, cfg.first_frame};
        hi     = lo + {1'b0, cfg.loop_length};
        fwd_n  = {2'b00, frame_reg} + (LOOP_BITS + 1)'(1);
        fwd_in = (fwd_n >= lo) && (fwd_n < hi);
        fwd_f  = fwd_in ? fwd_n[FRAME_BITS-1:0] : cfg.first_frame;
        prev_f = frame_reg - FRAME_BITS'(1);
        prev_x = {2'b00, prev_f};
        rev_in = (frame_reg != '0) && (prev_x >= lo) && (prev_x < hi);
        last_x = hi - (LOOP_BITS + 1)'(1);
        rev_f  = rev_in ? prev_f : last_x[FRAME_BITS-1:0];

        restart_f = (cfg.start_frame < cfg.first_frame) ? cfg.first_frame : cfg.start_frame;

        frame_next = frame_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        end_next   = end_reg;
        if (cmd == CMD_RESTART) begin
            frame_next = restart_f;
            acc_next   = '0;
            step_next  = '0;
            end_next   = 1'b0;
        end else if (live) begin
            acc_next = acc_sat;
            end_next = end_now;
            if (do_step) begin
                acc_next   = '0;
                step_next  = (step_reg == '1) ? step_reg : step_inc[STEP_BITS-1:0];
                frame_next = cfg.reverse ? rev_f : fwd_f;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            acc_reg   <= '0;
            step_reg  <= '0;
            end_reg   <= 1'b0;
            adv_reg   <= 1'b0;
        end else if (upd_en) begin
            frame_reg <= frame_next;
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            end_reg   <= end_next;
            adv_reg   <= (frame_next != frame_reg);
        end
    end

    assign anim.frame    = frame_reg;
    assign anim.advanced = adv_reg;
    assign anim.ended    = end_reg;

endmodule

### rtl/sfs_div.sv
// ----------------------------------------------------------------------------
// sfs_div
// restoring divider, one quotient bit per cycle, for frame row and column
// ----------------------------------------------------------------------------
module sfs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sfs_pkg::FRAME_BITS-1:0] dividend,
    input  logic [sfs_pkg::DIV_BITS-1:0]   divisor,
    output sfs_pkg::sfs_div_t             res
);
    import sfs_pkg::*;

    logic                  busy_reg, done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [FRAME_BITS-1:0] quo_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   dvs_reg;

    logic [DIV_BITS-1:0]   trial;
    logic                  fits;

    // remainder stays below the divisor, so its top bit is always clear
    assign trial = {rem_reg[DIV_BITS-2:0], quo_reg[FRAME_BITS-1]};
    assign fits  = (trial >= dvs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_BITS'(FRAME_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[FRAME_BITS-2:0], fits};
            rem_reg <= fits ? (trial - dvs_reg) : trial;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg[COL_BITS-1:0];

endmodule

### rtl/sprite_frame_sequencer_top.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top
// sprite-sheet animation stepper with sheet row and column lookup
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: cmd, tdata: elapsed
//  m_axis    out  m_axis_tvalid/m_axis_tready  frame, column, row, advanced, ended
//  cfg       in   cfg_we (no back-pressure)    cfg_index, cfg_wdata
//
//  each item passes through the state update, the divider load and the bit-serial
//  frame / columns division, then lands in the output register; a new item is
//  taken only once the last has reached it; the divider is the one arithmetic
//  unit the sequencer reuses. reset is synchronous, active low, and restores the
//  state, flags and configuration but not the divider operands or the payload
//  a stalled result sits in the output register while the next item is
//  taken; that item waits at the end of its division until the slot frees
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sfs_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,  // [15:0] elapsed
    input  logic [0:0]                          s_axis_tuser,  // [0] cmd
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] frame, [15:10] column, [25:16] row, [26] advanced, [27] ended, rest zero
    output logic [sfs_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [sfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import sfs_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an input transfer
    localparam logic [1:0] ST_START = 2'd1;  // state updated, load the divider
    localparam logic [1:0] ST_RUN   = 2'd2;  // dividing, then hand over

    logic [1:0]              state_reg, state_next;
    sfs_cfg_t                cfg_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0] m_data_reg;

    logic       s_xfer;
    logic       out_free;
    logic       load_out;
    sfs_anim_t  anim;
    sfs_div_t   div_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    // output slot is free when empty or being drained this cycle
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign load_out      = (state_reg == ST_RUN) && div_res.done && out_free;

    // configuration registers, read live by the animation state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_frame   <= '0;
            cfg_reg.loop_length   <= LOOP_BITS'(1);
            cfg_reg.start_frame   <= '0;
            cfg_reg.period        <= '0;
            cfg_reg.loop_enable   <= 1'b1;
            cfg_reg.reverse       <= 1'b0;
            cfg_reg.sheet_columns <= SHEET_BITS'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_FRAME:   cfg_reg.first_frame   <= cfg_wdata[FRAME_BITS-1:0];
                REG_LOOP_LENGTH:   cfg_reg.loop_length   <= cfg_wdata[LOOP_BITS-1:0];
                REG_START_FRAME:   cfg_reg.start_frame   <= cfg_wdata[FRAME_BITS-1:0];
                REG_PERIOD:        cfg_reg.period        <= cfg_wdata[TIME_BITS-1:0];
                REG_LOOP_ENABLE:   cfg_reg.loop_enable   <= cfg_wdata[0];
                REG_REVERSE:       cfg_reg.reverse       <= cfg_wdata[0];
                REG_SHEET_COLUMNS: cfg_reg.sheet_columns <= cfg_wdata[SHEET_BITS-1:0];
                default: begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    // animation state steps once per accepted transfer
    sfs_anim u_anim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd_en  (s_xfer),
        .cmd     (s_axis_tuser[0]),
        .elapsed (s_axis_tdata[ELAPSED_BITS-1:0]),
        .cfg     (cfg_reg),
        .anim    (anim)
    );

    // shared divider: frame / columns gives row, remainder gives column
    sfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_START),
        .dividend (anim.frame),
        .divisor  (clamp_cols(cfg_reg.sheet_columns)),
        .res      (div_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, packed from the lowest bit up
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {{OUT_PAD{1'b0}}, anim.ended, anim.advanced,
                           div_res.quotient, div_res.remainder, anim.frame};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### rtl/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// port-level checks for the sprite frame sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfs_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [sfs_pkg::M_TDATA_BITS-1:0]    m_axis_tdata
);
    import sfs_pkg::*;

    logic s_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // a stalled result holds its payload
    `SFS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // one item at a time: ready drops after each input transfer
    `SFS_ASSERT(a_busy_after_xfer, s_xfer |=> !s_axis_tready, "input taken while an item is in work")

    // no result can appear the cycle after an input transfer
    `SFS_ASSERT(a_no_instant_result, s_xfer && !m_axis_tvalid |=> !m_axis_tvalid, "result appeared without a division")

    // padding above the result fields stays zero
    `SFS_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[M_TDATA_BITS-1:OUT_BITS] == '0), "nonzero padding")

    // reset empties the output register
    `SFS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (.*);
